[hdl/fete_pkg.sv]
`default_nettype none

package fete_pkg;

    // table store geometry
    localparam int TABLE_BYTES = 16384;
    localparam int ADDR_W      = $clog2(TABLE_BYTES);
    localparam int LANES       = 4;
    localparam int ROWS        = TABLE_BYTES / LANES;
    localparam int ROW_W       = ADDR_W - 2;
    localparam int BOFF_W      = 30;
    localparam logic [BOFF_W:0] TABLE_END = (BOFF_W + 1)'(TABLE_BYTES);

    // field widths
    localparam int FUNC_W      = 2;
    localparam int CLUSTER_W   = 28;
    localparam int VALUE_W     = 32;
    localparam int BADDR_W     = 14;
    localparam int BYTE_W      = 8;
    localparam int SECTOR_W    = 32;
    localparam int OFFSET_W    = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 28;
    localparam int BASE_SUM_W  = 29;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_MARK   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_FORMAT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_LOG2    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_SECS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LEN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_TABLE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_TOTAL  = 3'd5;

    // entry codes and masks
    localparam logic [CLUSTER_W-1:0] EOF_FIRST        = 28'h0ffffff8;
    localparam logic [15:0]          FAT16_END_MIN    = 16'hfff8;
    localparam logic [CLUSTER_W-1:0] FAT16_WIDEN      = 28'h0fff0000;
    localparam logic [11:0]          FAT12_END_MIN    = 12'hff8;
    localparam logic [CLUSTER_W-1:0] FAT12_WIDEN      = 28'h0ffff000;
    localparam logic [31:0]          FAT32_KEEP       = 32'hf0000000;
    localparam logic [31:0]          FAT32_ENTRY_MASK = 32'h0fffffff;
    localparam logic [15:0]          FAT12_KEEP_ODD   = 16'h000f;
    localparam logic [15:0]          FAT12_KEEP_EVEN  = 16'hf000;
    localparam logic [11:0]          FAT12_ENTRY_MASK = 12'hfff;

    typedef enum logic [1:0] {
        FMT_12,
        FMT_16,
        FMT_32
    } fmt_t;

    typedef enum logic [2:0] {
        PLAN_LOAD,
        PLAN_READ,
        PLAN_EOF,
        PLAN_REJECT,
        PLAN_LOOKUP,
        PLAN_MARK,
        PLAN_NOFIT
    } plan_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        plan_t              plan;
        logic [BOFF_W-1:0]  base;
        fmt_t               fmt;
        logic               odd;
    } entry_map_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     base;
        logic [LANES-1:0]      mask;
        logic [LANES*8-1:0]    word;
    } store_wr_t;

endpackage

`default_nettype wire

[hdl/fat_entry_table_engine.sv]
`default_nettype none
// An accepted word moves to the execute state; its result is registered into
// the output register once that register is empty or being taken.
// No new word is taken until the execute state ends; the accept cycle issues the read
// of the four byte-lane banks, the execute state decodes and writes back.
// Reset clears the configuration to its defaults and empties the output
// register; table bytes are undefined until loaded or marked.

module fat_entry_table_engine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fete_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fete_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [fete_pkg::FUNC_W-1:0]     func,
    input  wire logic [fete_pkg::CLUSTER_W-1:0]  cluster,
    input  wire logic [fete_pkg::VALUE_W-1:0]    mark_value,
    input  wire logic [fete_pkg::BADDR_W-1:0]    byte_address,
    input  wire logic [fete_pkg::BYTE_W-1:0]     byte_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [fete_pkg::CLUSTER_W-1:0]  chain_link,
    output logic      [fete_pkg::SECTOR_W-1:0]   sector,
    output logic      [fete_pkg::OFFSET_W-1:0]   offset_in_sector,
    output logic      [fete_pkg::BYTE_W-1:0]     read_byte,
    output logic                                 status
);

    import fete_pkg::*;

    // configuration
    logic [1:0]  entry_format_reg;
    logic [3:0]  sector_size_log2_reg;
    logic [15:0] reserved_sector_count_reg;
    logic [23:0] table_length_sectors_reg;
    logic [3:0]  active_table_reg;
    logic [27:0] cluster_total_reg;
    fmt_t        fmt_eff;

    // control
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   exec_go;

    // item held for the execute state
    entry_map_t            map_now;
    entry_map_t            item_reg;
    logic [CLUSTER_W-1:0]  cluster_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [BYTE_W-1:0]     byte_value_reg;
    logic [BASE_SUM_W-1:0] base_sum_reg;

    // store
    logic [LANES*8-1:0] rd_word;
    store_wr_t          store_wr;

    // result
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CLUSTER_W-1:0] chain_link_reg;
    logic [CLUSTER_W-1:0] chain_link_next;
    logic [SECTOR_W-1:0]  sector_reg;
    logic [SECTOR_W-1:0]  sector_next;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [OFFSET_W-1:0]  offset_next;
    logic [BYTE_W-1:0]    read_byte_reg;
    logic [BYTE_W-1:0]    read_byte_next;
    logic                 status_reg;
    logic                 status_next;

    // decode helpers
    logic [1:0]           sh_sel;
    logic [BOFF_W-1:0]    base_shifted;
    logic [OFFSET_W-1:0]  offset_mask;
    logic [15:0]          w16;
    logic [11:0]          v12;
    logic [CLUSTER_W-1:0] lookup_nc;
    logic [31:0]          mark_word;
    logic [LANES-1:0]     mark_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_format_reg          <= 2'd0;
            sector_size_log2_reg      <= 4'd9;
            reserved_sector_count_reg <= 16'd1;
            table_length_sectors_reg  <= 24'd0;
            active_table_reg          <= 4'd0;
            cluster_total_reg         <= 28'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ENTRY_FORMAT:  entry_format_reg          <= cfg_data[1:0];
                CFG_SECTOR_LOG2:   sector_size_log2_reg      <= cfg_data[3:0];
                CFG_RESERVED_SECS: reserved_sector_count_reg <= cfg_data[15:0];
                CFG_TABLE_LEN:     table_length_sectors_reg  <= cfg_data[23:0];
                CFG_ACTIVE_TABLE:  active_table_reg          <= cfg_data[3:0];
                CFG_CLUSTER_TOTAL: cluster_total_reg         <= cfg_data[27:0];
                default:           ;
            endcase
        end
    end

    assign fmt_eff = (entry_format_reg >= 2'd2) ? FMT_32 : fmt_t'(entry_format_reg);

    // state machine
    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = exec_go ? ST_IDLE : ST_EXEC;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                exec_go  = 1'b0;
            end
            ST_EXEC:
            begin
                in_ready = 1'b0;
                exec_go  = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
                exec_go  = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    fete_entry_map u_map (
        .func          (func),
        .cluster       (cluster),
        .byte_address  (byte_address),
        .fmt           (fmt_eff),
        .cluster_total (cluster_total_reg),
        .map           (map_now)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg       <= map_now;
            cluster_reg    <= cluster;
            value_reg      <= mark_value;
            byte_value_reg <= byte_value;
            base_sum_reg   <= BASE_SUM_W'(reserved_sector_count_reg)
                            + BASE_SUM_W'(active_table_reg * table_length_sectors_reg);
        end
    end

    fete_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_base (map_now.base[ADDR_W-1:0]),
        .wr      (store_wr),
        .rd_word (rd_word)
    );

    // sector geometry; sizes outside 512..4096 clamp
    always_comb
    begin
        if (sector_size_log2_reg < 4'd9)
            sh_sel = 2'd0;
        else if (sector_size_log2_reg > 4'd12)
            sh_sel = 2'd3;
        else
            sh_sel = 2'(sector_size_log2_reg - 4'd9);
    end

    always_comb
    begin
        case (sh_sel)
            2'd0:
            begin
                base_shifted = item_reg.base >> 9;
                offset_mask  = 12'h1ff;
            end
            2'd1:
            begin
                base_shifted = item_reg.base >> 10;
                offset_mask  = 12'h3ff;
            end
            2'd2:
            begin
                base_shifted = item_reg.base >> 11;
                offset_mask  = 12'h7ff;
            end
            default:
            begin
                base_shifted = item_reg.base >> 12;
                offset_mask  = 12'hfff;
            end
        endcase
    end

    // entry decode and merge
    assign w16 = rd_word[15:0];
    assign v12 = item_reg.odd ? w16[15:4] : w16[11:0];

    always_comb
    begin
        case (item_reg.fmt)
            FMT_32:
            begin
                lookup_nc = rd_word[CLUSTER_W-1:0];
                mark_word = (rd_word & FAT32_KEEP) | (value_reg & FAT32_ENTRY_MASK);
                mark_mask = 4'b1111;
            end
            FMT_16:
            begin
                lookup_nc = (w16 >= FAT16_END_MIN) ? (FAT16_WIDEN | CLUSTER_W'(w16))
                                                   : CLUSTER_W'(w16);
                mark_word = {16'd0, value_reg[15:0]};
                mark_mask = 4'b0011;
            end
            default:
            begin
                lookup_nc = (v12 >= FAT12_END_MIN) ? (FAT12_WIDEN | CLUSTER_W'(v12))
                                                   : CLUSTER_W'(v12);
                if (item_reg.odd)
                    mark_word = {16'd0, (w16 & FAT12_KEEP_ODD)
                                      | {value_reg[11:0] & FAT12_ENTRY_MASK, 4'h0}};
                else
                    mark_word = {16'd0, (w16 & FAT12_KEEP_EVEN)
                                      | {4'h0, value_reg[11:0] & FAT12_ENTRY_MASK}};
                mark_mask = 4'b0011;
            end
        endcase
    end

    always_comb
    begin
        chain_link_next   = '0;
        sector_next       = '0;
        offset_next       = '0;
        read_byte_next    = '0;
        status_next       = 1'b0;
        store_wr.en       = 1'b0;
        store_wr.base     = item_reg.base[ADDR_W-1:0];
        store_wr.mask     = mark_mask;
        store_wr.word     = mark_word;
        case (item_reg.plan)
            PLAN_LOAD:
            begin
                store_wr.en   = exec_go;
                store_wr.mask = 4'b0001;
                store_wr.word = {24'd0, byte_value_reg};
            end
            PLAN_READ:
            begin
                read_byte_next = rd_word[7:0];
            end
            PLAN_EOF:
            begin
                chain_link_next = cluster_reg;
            end
            PLAN_REJECT:
            begin
                status_next = 1'b1;
            end
            PLAN_LOOKUP:
            begin
                sector_next     = SECTOR_W'(base_sum_reg) + SECTOR_W'(base_shifted);
                offset_next     = item_reg.base[OFFSET_W-1:0] & offset_mask;
                chain_link_next = lookup_nc;
            end
            PLAN_MARK:
            begin
                sector_next = SECTOR_W'(base_sum_reg) + SECTOR_W'(base_shifted);
                offset_next = item_reg.base[OFFSET_W-1:0] & offset_mask;
                store_wr.en = exec_go;
            end
            PLAN_NOFIT:
            begin
                sector_next = SECTOR_W'(base_sum_reg) + SECTOR_W'(base_shifted);
                offset_next = item_reg.base[OFFSET_W-1:0] & offset_mask;
                status_next = 1'b1;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    // output register
    assign out_valid_next = exec_go || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            chain_link_reg <= chain_link_next;
            sector_reg     <= sector_next;
            offset_reg     <= offset_next;
            read_byte_reg  <= read_byte_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign chain_link       = chain_link_reg;
    assign sector           = sector_reg;
    assign offset_in_sector = offset_reg;
    assign read_byte        = read_byte_reg;
    assign status           = status_reg;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not move to the execute cycle");

    a_exec_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg)
        else $error("finished word did not reach the output register");

    a_no_read_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && store_wr.en))
        else $error("store read and write overlap");

    a_mark_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && item_reg.plan == PLAN_MARK) |-> (store_wr.en && store_wr.mask != 4'b0000))
        else $error("mark finished without a store write");

endmodule

`default_nettype wire

[hdl/fete_ram.sv]
`default_nettype none

module fete_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/fete_store.sv]
`default_nettype none

module fete_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [fete_pkg::ADDR_W-1:0] rd_base,
    input  wire fete_pkg::store_wr_t         wr,
    output logic      [fete_pkg::LANES*8-1:0] rd_word
);

    import fete_pkg::*;

    logic [7:0] bank_q [LANES];
    logic [1:0] rd_lane_reg;

    // byte j of a word lives in bank (base + j) mod 4; banks below the
    // start lane take the next row
    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        logic [1:0]       wr_j;
        logic [ROW_W-1:0] wr_row;
        logic [ROW_W-1:0] rd_row;
        logic             bank_we;

        assign wr_j    = 2'(2'(b) - wr.base[1:0]);
        assign wr_row  = wr.base[ADDR_W-1:2] + ROW_W'(2'(b) < wr.base[1:0]);
        assign rd_row  = rd_base[ADDR_W-1:2] + ROW_W'(2'(b) < rd_base[1:0]);
        assign bank_we = wr.en & wr.mask[wr_j];

        fete_ram #(
            .DEPTH (ROWS),
            .WIDTH (8)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_we),
            .wr_addr (wr_row),
            .wr_data (wr.word[8*wr_j +: 8]),
            .rd_en   (rd_en),
            .rd_addr (rd_row),
            .rd_data (bank_q[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_lane_reg <= 2'd0;
        end
        else if (rd_en)
        begin
            rd_lane_reg <= rd_base[1:0];
        end
    end

    // rotate bank outputs back into word order
    for (genvar j = 0; j < LANES; j++)
    begin : g_rot
        assign rd_word[8*j +: 8] = bank_q[2'(rd_lane_reg + 2'(j))];
    end

endmodule

`default_nettype wire

[hdl/fete_entry_map.sv]
`default_nettype none

module fete_entry_map (
    input  wire logic [fete_pkg::FUNC_W-1:0]    func,
    input  wire logic [fete_pkg::CLUSTER_W-1:0] cluster,
    input  wire logic [fete_pkg::BADDR_W-1:0]   byte_address,
    input  wire fete_pkg::fmt_t                 fmt,
    input  wire logic [fete_pkg::CLUSTER_W-1:0] cluster_total,
    output fete_pkg::entry_map_t                map
);

    import fete_pkg::*;

    logic [BOFF_W-1:0] boff;
    logic [BOFF_W:0]   entry_end;
    logic [BOFF_W:0]   addr_ext;
    logic              addr_bad;
    logic              fit_bad;
    logic              cluster_bad;
    plan_t             plan;

    always_comb
    begin
        case (fmt)
            FMT_32:  boff = {cluster, 2'b00};
            FMT_16:  boff = {1'b0, cluster, 1'b0};
            default: boff = BOFF_W'(cluster) + BOFF_W'(cluster[CLUSTER_W-1:1]);
        endcase
    end

    assign entry_end   = {1'b0, boff}
                       + ((fmt == FMT_32) ? (BOFF_W + 1)'(4) : (BOFF_W + 1)'(2));
    assign fit_bad     = entry_end > TABLE_END;
    assign addr_ext    = (BOFF_W + 1)'(byte_address);
    assign addr_bad    = addr_ext >= TABLE_END;
    assign cluster_bad = cluster >= cluster_total;

    always_comb
    begin
        case (func)
            FUNC_LOAD: plan = addr_bad ? PLAN_REJECT : PLAN_LOAD;
            FUNC_READ: plan = addr_bad ? PLAN_REJECT : PLAN_READ;
            FUNC_LOOKUP:
            begin
                if (cluster >= EOF_FIRST)
                    plan = PLAN_EOF;
                else if (cluster_bad)
                    plan = PLAN_REJECT;
                else if (fit_bad)
                    plan = PLAN_NOFIT;
                else
                    plan = PLAN_LOOKUP;
            end
            default:
            begin
                if (cluster_bad)
                    plan = PLAN_REJECT;
                else if (fit_bad)
                    plan = PLAN_NOFIT;
                else
                    plan = PLAN_MARK;
            end
        endcase
    end

    assign map.plan = plan;
    assign map.base = (func == FUNC_LOAD || func == FUNC_READ) ?
                      addr_ext[BOFF_W-1:0] : boff;
    assign map.fmt  = fmt;
    assign map.odd  = cluster[0];

endmodule

`default_nettype wire

[bench/fete_result_checker.sv]
module fete_result_checker
    import fete_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [CLUSTER_W-1:0]   cluster,
    input  logic [VALUE_W-1:0]     mark_value,
    input  logic [BADDR_W-1:0]     byte_address,
    input  logic [BYTE_W-1:0]      byte_value,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [CLUSTER_W-1:0]   chain_link,
    input  logic [SECTOR_W-1:0]    sector,
    input  logic [OFFSET_W-1:0]    offset_in_sector,
    input  logic [BYTE_W-1:0]      read_byte,
    input  logic                   status,
    output int                     mismatches,
    output int                     pending,
    output int                     results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CLUSTER_W-1:0] chain_link;
        logic [SECTOR_W-1:0]  sector;
        logic [OFFSET_W-1:0]  offset;
        logic [BYTE_W-1:0]    rbyte;
        logic                 status;
    } entry_result_t;

    entry_result_t expected_q[$];
    logic [BYTE_W-1:0] table_copy [TABLE_BYTES];

    logic [1:0]           fmt_r;
    logic [3:0]           log2_r;
    logic [15:0]          rsv_r;
    logic [23:0]          tlen_r;
    logic [3:0]           act_r;
    logic [CLUSTER_W-1:0] total_r;

    function automatic entry_result_t predict_word(
        input logic [FUNC_W-1:0]    f,
        input logic [CLUSTER_W-1:0] cl,
        input logic [VALUE_W-1:0]   val,
        input logic [BADDR_W-1:0]   addr,
        input logic [BYTE_W-1:0]    bval
    );
        entry_result_t r;
        fmt_t          fm;
        int unsigned   sh;
        int unsigned   span;
        int unsigned   a;
        logic [63:0]   boff;
        logic [63:0]   sec_sum;
        logic [31:0]   w;
        logic [31:0]   nw;
        logic [11:0]   e12;
        r = '0;
        if (f == FUNC_LOAD || f == FUNC_READ) begin
            if (int'(addr) >= TABLE_BYTES)
                r.status = 1'b1;
            else if (f == FUNC_LOAD)
                table_copy[addr] = bval;
            else
                r.rbyte = table_copy[addr];
        end else if (f == FUNC_LOOKUP && cl >= EOF_FIRST) begin
            r.chain_link = cl;
        end else if (cl >= total_r) begin
            r.status = 1'b1;
        end else begin
            fm = (fmt_r == 2'd0) ? FMT_12 : (fmt_r == 2'd1) ? FMT_16 : FMT_32;
            sh = (log2_r < 4'd9) ? 9 : (log2_r > 4'd12) ? 12 : int'(log2_r);
            case (fm)
                FMT_32: begin
                    boff = 64'(cl) << 2;
                    span = 4;
                end
                FMT_16: begin
                    boff = 64'(cl) << 1;
                    span = 2;
                end
                default: begin
                    boff = 64'(cl) + 64'(cl >> 1);
                    span = 2;
                end
            endcase
            sec_sum = 64'(rsv_r) + 64'(act_r) * 64'(tlen_r) + (boff >> sh);
            r.sector = sec_sum[31:0];
            r.offset = OFFSET_W'(boff & ((64'd1 << sh) - 64'd1));
            if (boff + 64'(span) > 64'(TABLE_BYTES)) begin
                r.status = 1'b1;
            end else begin
                a = boff[31:0];
                w = {16'd0, table_copy[a + 1], table_copy[a]};
                if (fm == FMT_32)
                    w[31:16] = {table_copy[a + 3], table_copy[a + 2]};
                if (f == FUNC_LOOKUP) begin
                    case (fm)
                        FMT_32: r.chain_link = w[27:0];
                        FMT_16: begin
                            r.chain_link = CLUSTER_W'(w[15:0]);
                            if (w[15:0] >= FAT16_END_MIN)
                                r.chain_link = r.chain_link | FAT16_WIDEN;
                        end
                        default: begin
                            e12 = cl[0] ? w[15:4] : w[11:0];
                            r.chain_link = CLUSTER_W'(e12);
                            if (e12 >= FAT12_END_MIN)
                                r.chain_link = r.chain_link | FAT12_WIDEN;
                        end
                    endcase
                end else begin
                    // read-modify-write: keep the bits that belong to others
                    case (fm)
                        FMT_32: nw = (w & FAT32_KEEP) | (val & FAT32_ENTRY_MASK);
                        FMT_16: nw = {16'd0, val[15:0]};
                        default: begin
                            if (cl[0])
                                nw = {16'd0, (w[15:0] & FAT12_KEEP_ODD)
                                      | {val[11:0] & FAT12_ENTRY_MASK, 4'd0}};
                            else
                                nw = {16'd0, (w[15:0] & FAT12_KEEP_EVEN)
                                      | {4'd0, val[11:0] & FAT12_ENTRY_MASK}};
                        end
                    endcase
                    table_copy[a]     = nw[7:0];
                    table_copy[a + 1] = nw[15:8];
                    if (fm == FMT_32) begin
                        table_copy[a + 2] = nw[23:16];
                        table_copy[a + 3] = nw[31:24];
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        entry_result_t got;
        entry_result_t want;
        if (!rst_n) begin
            fmt_r   = 2'd0;
            log2_r  = 4'd9;
            rsv_r   = 16'd1;
            tlen_r  = '0;
            act_r   = '0;
            total_r = '0;
            expected_q.delete();
            pending      <= 0;
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ENTRY_FORMAT:  fmt_r   = cfg_data[1:0];
                    CFG_SECTOR_LOG2:   log2_r  = cfg_data[3:0];
                    CFG_RESERVED_SECS: rsv_r   = cfg_data[15:0];
                    CFG_TABLE_LEN:     tlen_r  = cfg_data[23:0];
                    CFG_ACTIVE_TABLE:  act_r   = cfg_data[3:0];
                    CFG_CLUSTER_TOTAL: total_r = cfg_data[CLUSTER_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                got = {chain_link, sector, offset_in_sector, read_byte, status};
                results_seen++;
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unpredicted result word: next=%h sector=%h off=%h byte=%h st=%b",
                                 $realtime, got.chain_link, got.sector, got.offset,
                                 got.rbyte, got.status);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: result %0d expected next=%h sector=%h off=%h byte=%h st=%b",
                                     $realtime, results_seen, want.chain_link, want.sector,
                                     want.offset, want.rbyte, want.status);
                            $display("%0t: result %0d actual   next=%h sector=%h off=%h byte=%h st=%b",
                                     $realtime, results_seen, got.chain_link, got.sector,
                                     got.offset, got.rbyte, got.status);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_word(func, cluster, mark_value,
                                                  byte_address, byte_value));
            pending <= expected_q.size();
        end
    end

endmodule

[bench/tb_fat_entry_table_engine.sv]
module tb_fat_entry_table_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import fete_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func;
    logic [CLUSTER_W-1:0]   cluster;
    logic [VALUE_W-1:0]     mark_value;
    logic [BADDR_W-1:0]     byte_address;
    logic [BYTE_W-1:0]      byte_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [CLUSTER_W-1:0]   chain_link;
    logic [SECTOR_W-1:0]    sector;
    logic [OFFSET_W-1:0]    offset_in_sector;
    logic [BYTE_W-1:0]      read_byte;
    logic                   status;

    int mismatch_count;
    int pending_count;
    int checked_count;

    int sender_idle_pct;
    int receiver_stall_pct;
    int op_count [4];
    int setting_count;

    // what the stimulus needs to know to keep away from unloaded bytes
    logic [1:0]           fmt_sh;
    logic [CLUSTER_W-1:0] total_sh;
    bit                   loaded [TABLE_BYTES];

    fat_entry_table_engine dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .cluster          (cluster),
        .mark_value       (mark_value),
        .byte_address     (byte_address),
        .byte_value       (byte_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .chain_link       (chain_link),
        .sector           (sector),
        .offset_in_sector (offset_in_sector),
        .read_byte        (read_byte),
        .status           (status)
    );

    fete_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .cluster          (cluster),
        .mark_value       (mark_value),
        .byte_address     (byte_address),
        .byte_value       (byte_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .chain_link       (chain_link),
        .sector           (sector),
        .offset_in_sector (offset_in_sector),
        .read_byte        (read_byte),
        .status           (status),
        .mismatches       (mismatch_count),
        .pending          (pending_count),
        .results_seen     (checked_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CLUSTER_W-1:0] cl,
                             input logic [VALUE_W-1:0] val, input logic [BADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] bval);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        cluster      <= cl;
        mark_value   <= val;
        byte_address <= addr;
        byte_value   <= bval;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        op_count[f]++;
    endtask

    task automatic load_byte(input int unsigned addr, input logic [BYTE_W-1:0] bval);
        send_word(FUNC_LOAD, CLUSTER_W'($urandom), $urandom, BADDR_W'(addr), bval);
        loaded[addr] = 1'b1;
    endtask

    task automatic issue_read(input int unsigned addr);
        if (!loaded[addr])
            load_byte(addr, BYTE_W'($urandom));
        send_word(FUNC_READ, CLUSTER_W'($urandom), $urandom, BADDR_W'(addr),
                  BYTE_W'($urandom));
    endtask

    // load any byte of the entry that was never written, then send the lookup or mark
    task automatic issue_entry(input logic [FUNC_W-1:0] f, input logic [CLUSTER_W-1:0] cl,
                               input logic [VALUE_W-1:0] val);
        int unsigned boff;
        int unsigned span;
        bit          touches;
        touches = !(f == FUNC_LOOKUP && cl >= EOF_FIRST) && (cl < total_sh);
        span = (fmt_sh >= 2'd2) ? 4 : 2;
        boff = (fmt_sh >= 2'd2) ? cl * 4 : (fmt_sh == 2'd1) ? cl * 2 : cl + (cl >> 1);
        if (touches && boff + span <= TABLE_BYTES) begin
            for (int k = 0; k < span; k++)
                if (!loaded[boff + k])
                    load_byte(boff + k, ($urandom_range(2) == 0) ? 8'hff : BYTE_W'($urandom));
        end
        send_word(f, cl, val, BADDR_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [1:0] fmt, input logic [3:0] lg,
                                input logic [15:0] rsv, input logic [23:0] tlen,
                                input logic [3:0] act, input logic [CLUSTER_W-1:0] total,
                                input bit junk);
        logic [CFG_DATA_W-1:0] hi;
        // junk in the bits above each register's width must be dropped
        hi = junk ? CFG_DATA_W'($urandom) : '0;
        write_reg(CFG_ENTRY_FORMAT,  {hi[27:2], fmt});
        write_reg(CFG_SECTOR_LOG2,   {hi[27:4], lg});
        write_reg(CFG_RESERVED_SECS, {hi[27:16], rsv});
        write_reg(CFG_TABLE_LEN,     {hi[27:24], tlen});
        write_reg(CFG_ACTIVE_TABLE,  {hi[27:4], act});
        write_reg(CFG_CLUSTER_TOTAL, total);
        cfg_wr_en <= 1'b0;
        fmt_sh   = fmt;
        total_sh = total;
        setting_count++;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        int unsigned       edge_cl;
        int unsigned       addr;
        int                r;
        logic [CLUSTER_W-1:0] cl;
        logic [VALUE_W-1:0]   val;
        edge_cl = (fmt_sh >= 2'd2) ? 4096 : (fmt_sh == 2'd1) ? 8192 : 10922;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            addr = ($urandom_range(9) < 7) ? $urandom_range(255) : $urandom_range(TABLE_BYTES - 1);
            if (r < 12) begin
                load_byte(addr, BYTE_W'($urandom));
            end else if (r < 24) begin
                issue_read(addr);
            end else begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: cl = CLUSTER_W'($urandom_range(47));
                    11, 12: cl = CLUSTER_W'(edge_cl - 3 + $urandom_range(5));
                    13, 14: cl = total_sh - 28'd2 + CLUSTER_W'($urandom_range(3));
                    15, 16: cl = EOF_FIRST + CLUSTER_W'($urandom_range(7));
                    default: cl = CLUSTER_W'($urandom);
                endcase
                val = $urandom;
                // bias toward end-of-chain codes so lookups widen them
                if ($urandom_range(2) == 0)
                    val = val | 32'h0ffffff0;
                issue_entry((r < 62) ? FUNC_LOOKUP : FUNC_MARK, cl, val);
            end
        end
    endtask

    initial begin
        int mode;
        logic [3:0]  lg;
        logic [15:0] rsv;
        logic [23:0] tlen;
        logic [3:0]  act;
        logic [CLUSTER_W-1:0] total;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        func               = FUNC_LOAD;
        cluster            = '0;
        mark_value         = '0;
        byte_address       = '0;
        byte_value         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        setting_count      = 0;
        fmt_sh             = 2'd0;
        total_sh           = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: FAT12, the store ends, end codes, range and fit edges, nibble merge
        program_regs(2'd0, 4'd9, 16'd1, 24'h000100, 4'd1, 28'd20000, 1'b0);
        load_byte(0, 8'hff);
        load_byte(TABLE_BYTES - 1, 8'ha5);
        issue_read(0);
        issue_read(TABLE_BYTES - 1);
        issue_entry(FUNC_LOOKUP, EOF_FIRST, $urandom);
        issue_entry(FUNC_LOOKUP, 28'h0fffffff, $urandom);
        issue_entry(FUNC_MARK, 28'h0fffffff, $urandom);
        issue_entry(FUNC_LOOKUP, 28'd20000, $urandom);
        issue_entry(FUNC_MARK, 28'd19999, $urandom);
        issue_entry(FUNC_MARK, 28'd2, 32'hffffffff);
        issue_entry(FUNC_MARK, 28'd3, 32'h00000123);
        issue_entry(FUNC_LOOKUP, 28'd2, '0);
        issue_entry(FUNC_LOOKUP, 28'd3, '0);
        issue_entry(FUNC_MARK, 28'd2, '0);
        issue_entry(FUNC_LOOKUP, 28'd2, '0);
        issue_entry(FUNC_LOOKUP, 28'd3, '0);
        issue_entry(FUNC_MARK, 28'd3, 32'hfffffffe);
        issue_entry(FUNC_LOOKUP, 28'd3, '0);
        issue_entry(FUNC_LOOKUP, 28'd10921, '0);
        issue_entry(FUNC_MARK, 28'd10921, 32'h00000abc);
        issue_entry(FUNC_LOOKUP, 28'd10921, '0);
        issue_entry(FUNC_LOOKUP, 28'd10922, '0);
        issue_entry(FUNC_MARK, 28'd10922, 32'h00000001);
        issue_entry(FUNC_MARK, 28'd0, '0);
        issue_entry(FUNC_LOOKUP, 28'd0, '0);

        for (int p = 0; p < 9; p++) begin
            drain();
            case (p)
                0: lg = 4'd9;
                1: lg = 4'd0;
                2: lg = 4'd15;
                3: lg = 4'd12;
                default: lg = 4'($urandom_range(9, 12));
            endcase
            rsv  = (p == 4) ? 16'hffff : (p == 5) ? 16'd0 : 16'($urandom);
            tlen = (p == 4) ? 24'hffffff : (p == 5) ? 24'd0 : 24'($urandom);
            act  = (p == 4) ? 4'd15 : (p == 5) ? 4'd0 : 4'($urandom);
            case (p % 3)
                0: total = 28'h0fffffff;
                1: total = CLUSTER_W'($urandom_range(30, 60));
                default: total = CLUSTER_W'($urandom_range(3000, 12000));
            endcase
            program_regs(2'(p % 4), lg, rsv, tlen, act, total, p[0]);
            mode = (p / 2) % 4;
            sender_idle_pct    = (mode == 1) ? 57 : (mode == 3) ? 12 : 0;
            receiver_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 12 : 0;
            run_phase(100);
        end

        drain();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Covered %0d loads, %0d reads, %0d lookups, %0d marks over %0d settings",
                 op_count[FUNC_LOAD], op_count[FUNC_READ], op_count[FUNC_LOOKUP],
                 op_count[FUNC_MARK], setting_count);
        $display("%0d result words compared, %0d mismatched", checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
